### rtl/dkri_pkg.sv
// ----------------------------------------------------------------------------
// dkri_pkg
// Shared types, codes and bit helpers of the dense key rank index.
// ----------------------------------------------------------------------------
package dkri_pkg;

    localparam int KEY_W     = 64;
    localparam int ID_W      = 17;
    localparam int WORD_W    = 64;
    localparam int WORD_SH   = 6;
    localparam int BIT_W     = 6;
    localparam int POP_W     = 7;
    localparam int MAP_BITS_DEF = 65536;
    localparam logic [KEY_W-1:0] MAX_KEY_RST = 64'd65535;

    typedef enum logic [2:0] {
        FN_INSERT = 3'd0,
        FN_FIND   = 3'd1,
        FN_SEEK   = 3'd2,
        FN_FIRST  = 3'd3,
        FN_LAST   = 3'd4,
        FN_NEXT   = 3'd5,
        FN_PREV   = 3'd6,
        FN_NONE   = 3'd7
    } func_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_END   = 2'd1,
        ST_RANGE = 2'd2,
        ST_RSVD  = 2'd3
    } status_t;

    localparam logic [1:0] ORD_EQUAL  = 2'd0;
    localparam logic [1:0] ORD_LOWER  = 2'd1;
    localparam logic [1:0] LEN_EXACT  = 2'd0;
    localparam logic [1:0] LEN_LONGER = 2'd2;

    localparam logic CFG_MIN_KEY = 1'b0;
    localparam logic CFG_MAX_KEY = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0] min_key;
        logic [KEY_W-1:0] max_key;
    } cfg_t;

    function automatic logic [POP_W-1:0] pop64(input logic [WORD_W-1:0] x);
        logic [POP_W-1:0] n;
        n = '0;
        for (int i = 0; i < WORD_W; i++) begin
            n = n + POP_W'(x[i]);
        end
        return n;
    endfunction

    function automatic logic [BIT_W-1:0] low_bit(input logic [WORD_W-1:0] x);
        logic [BIT_W-1:0] b;
        b = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (x[i]) begin
                b = BIT_W'(i);
            end
        end
        return b;
    endfunction

    function automatic logic [BIT_W-1:0] high_bit(input logic [WORD_W-1:0] x);
        logic [BIT_W-1:0] b;
        b = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if (x[i]) begin
                b = BIT_W'(i);
            end
        end
        return b;
    endfunction

endpackage

### rtl/dkri_map_ram.sv
// ----------------------------------------------------------------------------
// dkri_map_ram
// Presence bitmap storage, one write port and one registered read port.
// ----------------------------------------------------------------------------
module dkri_map_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                          aclk,
    input  logic                          we,
    input  logic [AW-1:0]                 waddr,
    input  logic [dkri_pkg::WORD_W-1:0]   wdata,
    input  logic [AW-1:0]                 raddr,
    output logic [dkri_pkg::WORD_W-1:0]   rdata
);

    logic [dkri_pkg::WORD_W-1:0] mem [DEPTH];
    logic [dkri_pkg::WORD_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/dkri_engine.sv
// ----------------------------------------------------------------------------
// dkri_engine
// Command sequencer: decode, bitmap read-modify-write, word scans, rank count.
// ----------------------------------------------------------------------------
module dkri_engine #(
    parameter int MAP_BITS = dkri_pkg::MAP_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  dkri_pkg::cfg_t                cfg,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [2:0]                    s_func,
    input  logic [dkri_pkg::KEY_W-1:0]    s_key_value,
    input  logic [1:0]                    s_prefix_order,
    input  logic [1:0]                    s_length_class,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_status,
    output logic [dkri_pkg::ID_W-1:0]     m_key_id,
    output logic [dkri_pkg::KEY_W-1:0]    m_key_out,
    output logic [dkri_pkg::ID_W-1:0]     m_key_count
);

    localparam int PW = $clog2(MAP_BITS);
    localparam int NW = MAP_BITS / dkri_pkg::WORD_W;
    localparam int WA = (NW > 1) ? $clog2(NW) : 1;
    localparam logic [PW-1:0] POS_MAX = PW'(MAP_BITS - 1);
    localparam logic [WA-1:0] W_LAST  = WA'(NW - 1);
    localparam int KW = dkri_pkg::KEY_W;
    localparam int IW = dkri_pkg::ID_W;
    localparam int DW = dkri_pkg::WORD_W;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DECODE, S_RMW_RD, S_RMW_CHK,
        S_UP_RD, S_UP_CHK, S_DN_RD, S_DN_CHK, S_RANK
    } state_t;

    state_t                state_reg;
    dkri_pkg::func_t       func_reg;
    logic [KW-1:0]         key_reg;
    logic [1:0]            porder_reg;
    logic [1:0]            lclass_reg;
    logic [PW-1:0]         pos_reg;
    logic [WA-1:0]         w_reg;
    logic                  first_reg;
    logic [WA-1:0]         ra_reg;
    logic                  issue_reg;
    logic                  dv_reg;
    logic                  dlast_reg;
    logic [IW-1:0]         acc_reg;
    logic [PW-1:0]         cur_pos_reg;
    logic [IW-1:0]         cur_id_reg;
    logic                  cur_valid_reg;
    logic [IW-1:0]         count_reg;
    logic                  m_valid_reg;
    dkri_pkg::status_t     m_status_reg;
    logic [IW-1:0]         m_key_id_reg;
    logic [KW-1:0]         m_key_out_reg;

    logic [KW-1:0]         diff;
    logic                  below;
    logic                  in_range;
    logic [PW-1:0]         p;
    logic [WA-1:0]         pos_word;
    logic [dkri_pkg::BIT_W-1:0] pos_bit;
    logic [DW-1:0]         rdata;
    logic                  bit_set;
    logic [DW-1:0]         up_m;
    logic [DW-1:0]         dn_m;
    logic [DW-1:0]         rank_m;
    logic [IW-1:0]         rank_sum;
    logic [KW-1:0]         out_key;
    logic                  ram_we;
    logic [WA-1:0]         ram_waddr;
    logic [DW-1:0]         ram_wdata;
    logic [WA-1:0]         ram_raddr;

    assign diff     = key_reg - cfg.min_key;
    assign below    = key_reg < cfg.min_key;
    assign in_range = !below && (key_reg <= cfg.max_key) && (diff < KW'(MAP_BITS));
    assign p        = diff[PW-1:0];
    assign pos_word = WA'(pos_reg >> dkri_pkg::WORD_SH);
    assign pos_bit  = pos_reg[dkri_pkg::BIT_W-1:0];
    assign bit_set  = rdata[pos_bit];
    assign up_m     = rdata & (first_reg ? ({DW{1'b1}} << pos_bit) : {DW{1'b1}});
    assign dn_m     = rdata & (first_reg ? ({DW{1'b1}} >> (6'd63 - pos_bit)) : {DW{1'b1}});
    assign rank_m   = rdata & (dlast_reg ? ((DW'(1) << pos_bit) - DW'(1)) : {DW{1'b1}});
    assign rank_sum = acc_reg + IW'(dkri_pkg::pop64(rank_m));
    assign out_key  = cfg.min_key + KW'(pos_reg);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = pos_word;
        ram_wdata = rdata | (DW'(1) << pos_bit);
        ram_raddr = pos_word;
        unique case (state_reg)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = w_reg;
                ram_wdata = '0;
            end
            S_RMW_CHK: begin
                ram_we = (func_reg == dkri_pkg::FN_INSERT) && !bit_set;
            end
            S_UP_RD, S_DN_RD: begin
                ram_raddr = w_reg;
            end
            S_RANK: begin
                ram_raddr = ra_reg;
            end
            default: begin
            end
        endcase
    end

    dkri_map_ram #(
        .DEPTH (NW),
        .AW    (WA)
    ) u_map (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            w_reg         <= '0;
            cur_valid_reg <= 1'b0;
            cur_pos_reg   <= '0;
            cur_id_reg    <= '0;
            count_reg     <= '0;
            m_valid_reg   <= 1'b0;
            issue_reg     <= 1'b0;
            dv_reg        <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR: begin
                    if (w_reg == W_LAST) begin
                        state_reg <= S_IDLE;
                    end else begin
                        w_reg <= w_reg + WA'(1);
                    end
                end
                S_IDLE: begin
                    if (s_valid && s_ready) begin
                        func_reg   <= dkri_pkg::func_t'(s_func);
                        key_reg    <= s_key_value;
                        porder_reg <= s_prefix_order;
                        lclass_reg <= s_length_class;
                        state_reg  <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    m_status_reg  <= (func_reg == dkri_pkg::FN_INSERT) ?
                                     dkri_pkg::ST_RANGE : dkri_pkg::ST_END;
                    m_key_id_reg  <= '0;
                    m_key_out_reg <= '0;
                    first_reg     <= 1'b1;
                    unique case (func_reg)
                        dkri_pkg::FN_INSERT: begin
                            if (!in_range) begin
                                state_reg   <= S_IDLE;
                                m_valid_reg <= 1'b1;
                            end else begin
                                pos_reg     <= p;
                                state_reg   <= S_RMW_RD;
                            end
                        end
                        dkri_pkg::FN_FIND: begin
                            if (porder_reg == dkri_pkg::ORD_EQUAL &&
                                lclass_reg == dkri_pkg::LEN_EXACT && in_range) begin
                                pos_reg     <= p;
                                state_reg   <= S_RMW_RD;
                            end else begin
                                state_reg   <= S_IDLE;
                                m_valid_reg <= 1'b1;
                            end
                        end
                        dkri_pkg::FN_SEEK: begin
                            if (porder_reg == dkri_pkg::ORD_LOWER ||
                                (porder_reg == dkri_pkg::ORD_EQUAL && below)) begin
                                pos_reg     <= '0;
                                w_reg       <= '0;
                                state_reg   <= S_UP_RD;
                            end else if (porder_reg != dkri_pkg::ORD_EQUAL || !in_range) begin
                                cur_valid_reg <= 1'b0;
                                state_reg     <= S_IDLE;
                                m_valid_reg   <= 1'b1;
                            end else begin
                                pos_reg     <= p;
                                state_reg   <= S_RMW_RD;
                            end
                        end
                        dkri_pkg::FN_FIRST: begin
                            pos_reg     <= '0;
                            w_reg       <= '0;
                            state_reg   <= S_UP_RD;
                        end
                        dkri_pkg::FN_LAST: begin
                            pos_reg     <= POS_MAX;
                            w_reg       <= W_LAST;
                            state_reg   <= S_DN_RD;
                        end
                        dkri_pkg::FN_NEXT: begin
                            if (!cur_valid_reg || cur_pos_reg == POS_MAX) begin
                                cur_valid_reg <= 1'b0;
                                state_reg     <= S_IDLE;
                                m_valid_reg   <= 1'b1;
                            end else begin
                                pos_reg     <= cur_pos_reg + PW'(1);
                                w_reg       <= WA'((cur_pos_reg + PW'(1)) >> dkri_pkg::WORD_SH);
                                state_reg   <= S_UP_RD;
                            end
                        end
                        dkri_pkg::FN_PREV: begin
                            if (!cur_valid_reg || cur_pos_reg == '0) begin
                                cur_valid_reg <= 1'b0;
                                state_reg     <= S_IDLE;
                                m_valid_reg   <= 1'b1;
                            end else begin
                                pos_reg     <= cur_pos_reg - PW'(1);
                                w_reg       <= WA'((cur_pos_reg - PW'(1)) >> dkri_pkg::WORD_SH);
                                state_reg   <= S_DN_RD;
                            end
                        end
                        default: begin
                            state_reg   <= S_IDLE;
                            m_valid_reg <= 1'b1;
                        end
                    endcase
                end
                S_RMW_RD: begin
                    state_reg <= S_RMW_CHK;
                end
                S_RMW_CHK: begin
                    ra_reg    <= '0;
                    acc_reg   <= '0;
                    dv_reg    <= 1'b0;
                    first_reg <= 1'b1;
                    if (func_reg == dkri_pkg::FN_INSERT) begin
                        issue_reg <= 1'b1;
                        state_reg <= S_RANK;
                        if (!bit_set) begin
                            count_reg <= count_reg + IW'(1);
                            if (cur_valid_reg && pos_reg < cur_pos_reg) begin
                                cur_id_reg <= cur_id_reg + IW'(1);
                            end
                        end
                    end else if (func_reg == dkri_pkg::FN_FIND) begin
                        if (!bit_set) begin
                            issue_reg    <= 1'b0;
                            state_reg    <= S_IDLE;
                            m_valid_reg  <= 1'b1;
                            m_status_reg <= dkri_pkg::ST_END;
                            m_key_id_reg <= '0;
                            m_key_out_reg <= '0;
                        end else begin
                            issue_reg <= 1'b1;
                            state_reg <= S_RANK;
                        end
                    end else begin
                        issue_reg <= 1'b0;
                        if (lclass_reg == dkri_pkg::LEN_LONGER && bit_set) begin
                            if (pos_reg == POS_MAX) begin
                                state_reg     <= S_IDLE;
                                cur_valid_reg <= 1'b0;
                                m_valid_reg   <= 1'b1;
                                m_status_reg  <= dkri_pkg::ST_END;
                                m_key_id_reg  <= '0;
                                m_key_out_reg <= '0;
                            end else begin
                                pos_reg   <= pos_reg + PW'(1);
                                w_reg     <= WA'((pos_reg + PW'(1)) >> dkri_pkg::WORD_SH);
                                state_reg <= S_UP_RD;
                            end
                        end else begin
                            w_reg     <= pos_word;
                            state_reg <= S_UP_RD;
                        end
                    end
                end
                S_UP_RD: begin
                    state_reg <= S_UP_CHK;
                end
                S_DN_RD: begin
                    state_reg <= S_DN_CHK;
                end
                S_UP_CHK, S_DN_CHK: begin
                    first_reg <= 1'b0;
                    if ((state_reg == S_UP_CHK) ? (up_m != '0) : (dn_m != '0)) begin
                        pos_reg <= PW'({w_reg, (state_reg == S_UP_CHK) ?
                                        dkri_pkg::low_bit(up_m) : dkri_pkg::high_bit(dn_m)});
                        if (func_reg == dkri_pkg::FN_NEXT || func_reg == dkri_pkg::FN_PREV) begin
                            state_reg <= S_RANK;
                            acc_reg   <= (func_reg == dkri_pkg::FN_NEXT) ?
                                         cur_id_reg + IW'(1) : cur_id_reg - IW'(1);
                            issue_reg <= 1'b0;
                            dv_reg    <= 1'b0;
                        end else begin
                            state_reg <= S_RANK;
                            ra_reg    <= '0;
                            acc_reg   <= '0;
                            issue_reg <= 1'b1;
                            dv_reg    <= 1'b0;
                        end
                    end else if ((state_reg == S_UP_CHK) ? (w_reg == W_LAST) : (w_reg == '0)) begin
                        state_reg     <= S_IDLE;
                        cur_valid_reg <= 1'b0;
                        m_valid_reg   <= 1'b1;
                        m_status_reg  <= dkri_pkg::ST_END;
                        m_key_id_reg  <= '0;
                        m_key_out_reg <= '0;
                    end else begin
                        w_reg     <= (state_reg == S_UP_CHK) ? w_reg + WA'(1) : w_reg - WA'(1);
                        state_reg <= (state_reg == S_UP_CHK) ? S_UP_RD : S_DN_RD;
                    end
                end
                S_RANK: begin
                    dv_reg <= issue_reg;
                    if (issue_reg) begin
                        dlast_reg <= (ra_reg == pos_word);
                        if (ra_reg == pos_word) begin
                            issue_reg <= 1'b0;
                        end else begin
                            ra_reg <= ra_reg + WA'(1);
                        end
                    end
                    if (dv_reg) begin
                        acc_reg <= rank_sum;
                    end
                    if ((dv_reg && dlast_reg) || (!issue_reg && !dv_reg)) begin
                        state_reg     <= S_IDLE;
                        m_valid_reg   <= 1'b1;
                        m_status_reg  <= dkri_pkg::ST_OK;
                        m_key_id_reg  <= dv_reg ? rank_sum : acc_reg;
                        m_key_out_reg <= out_key;
                        if (func_reg != dkri_pkg::FN_INSERT && func_reg != dkri_pkg::FN_FIND) begin
                            cur_valid_reg <= 1'b1;
                            cur_pos_reg   <= pos_reg;
                            cur_id_reg    <= dv_reg ? rank_sum : acc_reg;
                        end
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_ready     = (state_reg == S_IDLE) && !m_valid_reg;
    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_key_id    = m_key_id_reg;
    assign m_key_out   = m_key_out_reg;
    assign m_key_count = count_reg;

endmodule

### rtl/dense_key_rank_index.sv
// ----------------------------------------------------------------------------
// dense_key_rank_index
// Rank/select index over dense integer keys held as a presence bitmap.
// ----------------------------------------------------------------------------
// One command at a time. After reset the bitmap memory is cleared one word per
// cycle, all MAP_BITS/64 words (1024 by default), with s_ready low. From its
// beat a command is decoded; insert, find and an in-range equal seek then read
// the key's word; a first/next/seek/last/prev walk reads word after word until
// a set bit is found; a landing next/prev takes its rank from the cursor, and
// any other landing command runs a rank walk that reads words 0 through the
// key's word w. Results wait in an output register and s_ready rises the cycle
// after the result beat is taken; key_count reflects the map after the command.
module dense_key_rank_index #(
    parameter int MAP_BITS = dkri_pkg::MAP_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [dkri_pkg::KEY_W-1:0]    cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [2:0]                    s_func,
    input  logic [dkri_pkg::KEY_W-1:0]    s_key_value,
    input  logic [1:0]                    s_prefix_order,
    input  logic [1:0]                    s_length_class,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_status,
    output logic [dkri_pkg::ID_W-1:0]     m_key_id,
    output logic [dkri_pkg::KEY_W-1:0]    m_key_out,
    output logic [dkri_pkg::ID_W-1:0]     m_key_count
);

    dkri_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_key <= '0;
            cfg_reg.max_key <= dkri_pkg::MAX_KEY_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                dkri_pkg::CFG_MIN_KEY: cfg_reg.min_key <= cfg_data;
                dkri_pkg::CFG_MAX_KEY: cfg_reg.max_key <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    dkri_engine #(
        .MAP_BITS (MAP_BITS)
    ) u_engine (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_key_value    (s_key_value),
        .s_prefix_order (s_prefix_order),
        .s_length_class (s_length_class),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_key_id       (m_key_id),
        .m_key_out      (m_key_out),
        .m_key_count    (m_key_count)
    );

endmodule
